// File: hdl/mrfe_pkg.sv
package mrfe_pkg;

    localparam int SCREEN_W_DEF = 640;
    localparam int SCREEN_H_DEF = 400;

    localparam int MODE_W   = 4;
    localparam int COORD_W  = 11;
    localparam int SPAN_W   = 10;
    localparam int HEIGHT_W = 9;
    localparam int RADIUS_W = 9;

    typedef enum logic [MODE_W-1:0] {
        MODE_SET_PIXEL = 4'd0,
        MODE_CLR_PIXEL = 4'd1,
        MODE_SET_BYTE  = 4'd2,
        MODE_CLR_BYTE  = 4'd3,
        MODE_SET_SPAN  = 4'd4,
        MODE_CLR_SPAN  = 4'd5,
        MODE_XOR_SPAN  = 4'd6,
        MODE_FILL_RECT = 4'd7,
        MODE_CLR_RECT  = 4'd8,
        MODE_XOR_CIRC  = 4'd9,
        MODE_READ_BYTE = 4'd10
    } mode_t;

    typedef enum logic [1:0] {
        OP_SET = 2'd0,
        OP_CLR = 2'd1,
        OP_XOR = 2'd2
    } op_t;

    // span request from the controller to the datapath
    typedef struct packed {
        logic                       start;
        op_t                        op;
        // whole byte: clip at the end of the row bytes, not at the screen edge
        logic                       whole;
        logic signed [COORD_W+1:0]  x;
        logic signed [COORD_W+1:0]  y;
        logic signed [COORD_W+1:0]  w;
    } span_cmd_t;

    typedef struct packed {
        logic busy;
    } span_sts_t;

endpackage

// File: hdl/mrfe_ram.sv
module mrfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/mrfe_datapath.sv
module mrfe_datapath #(
    parameter int SCREEN_W = mrfe_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H = mrfe_pkg::SCREEN_H_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  mrfe_pkg::span_cmd_t cmd,
    output mrfe_pkg::span_sts_t sts,
    input  logic               rd_req,
    input  logic [$clog2(SCREEN_H)-1:0] rd_row,
    input  logic [$clog2((SCREEN_W+7)/8)-1:0] rd_col,
    output logic [7:0]         rd_data,
    output logic               clr_busy
);
    import mrfe_pkg::*;

    localparam int ROW_BYTES = (SCREEN_W + 7) / 8;
    localparam int FB_SIZE   = ROW_BYTES * SCREEN_H;
    localparam int AW        = $clog2(FB_SIZE);
    localparam int CW        = $clog2(ROW_BYTES);
    localparam int RW        = $clog2(SCREEN_H);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_RD, S_WAIT, S_WR
    } state_t;

    state_t          state_reg;
    logic [AW-1:0]   clr_addr_reg;
    logic [AW-1:0]   row_base_reg;
    logic [CW-1:0]   col_reg;
    logic [CW-1:0]   col_end_reg;
    logic [2:0]      lo_reg;
    logic [2:0]      hi_reg;
    op_t             op_reg;

    logic            we;
    logic [AW-1:0]   waddr;
    logic [7:0]      wdata;
    logic [AW-1:0]   raddr;
    logic [7:0]      rdata;
    logic [7:0]      mask;
    logic [2:0]      lo_c;
    logic [2:0]      hi_c;

    logic signed [COORD_W+1:0] xs;
    logic signed [COORD_W+1:0] xe;
    logic signed [COORD_W+1:0] xe_lim;
    logic                      span_ok;
    logic [AW-1:0]             base_calc;

    always_comb
    begin
        xs = (cmd.x < 0) ? '0 : cmd.x;
        xe = cmd.x + cmd.w - (COORD_W+2)'(1);
        xe_lim = cmd.whole ? (COORD_W+2)'(ROW_BYTES * 8 - 1) : (COORD_W+2)'(SCREEN_W - 1);
        if (xe > xe_lim)
        begin
            xe = xe_lim;
        end
        span_ok = (cmd.w > 0) && (cmd.y >= 0) && (cmd.y < (COORD_W+2)'(SCREEN_H))
                  && (xs <= xe);
        base_calc = AW'(cmd.y[RW-1:0] * ROW_BYTES);
    end

    always_comb
    begin
        lo_c  = lo_reg;
        hi_c  = (col_reg == col_end_reg) ? hi_reg : 3'd7;
        mask  = (8'hFF >> lo_c) & (8'hFF << (3'd7 - hi_c));
        raddr = (state_reg == S_IDLE && rd_req) ?
                AW'(rd_row * ROW_BYTES) + AW'(rd_col) : row_base_reg + AW'(col_reg);
        we    = 1'b0;
        waddr = row_base_reg + AW'(col_reg);
        wdata = rdata;
        case (state_reg)
            S_CLEAR:
            begin
                we    = 1'b1;
                waddr = clr_addr_reg;
                wdata = 8'h00;
            end
            S_WR:
            begin
                we = 1'b1;
                case (op_reg)
                    OP_SET:  wdata = rdata | mask;
                    OP_CLR:  wdata = rdata & ~mask;
                    default: wdata = rdata ^ mask;
                endcase
            end
            default: ;
        endcase
    end

    mrfe_ram #(.WIDTH(8), .DEPTH(FB_SIZE)) u_fb (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + AW'(1);
                    if (clr_addr_reg == AW'(FB_SIZE - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (cmd.start && span_ok)
                    begin
                        row_base_reg <= base_calc;
                        col_reg      <= CW'(xs >>> 3);
                        col_end_reg  <= CW'(xe >>> 3);
                        lo_reg       <= xs[2:0];
                        hi_reg       <= xe[2:0];
                        op_reg       <= cmd.op;
                        state_reg    <= S_RD;
                    end
                end
                S_RD:   state_reg <= S_WAIT;
                S_WAIT: state_reg <= S_WR;
                S_WR:
                begin
                    lo_reg <= 3'd0;
                    if (col_reg == col_end_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        col_reg   <= col_reg + CW'(1);
                        state_reg <= S_RD;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign sts.busy = (state_reg != S_IDLE);
    assign clr_busy = (state_reg == S_CLEAR);
    assign rd_data  = rdata;

`ifndef SYNTHESIS
    ap_clear_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR && clr_addr_reg == AW'(FB_SIZE - 1)) |=> state_reg == S_IDLE)
        else $error("clear pass did not end");
    ap_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WR) |-> col_reg <= col_end_reg)
        else $error("span column past end");
    ap_wr_after_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WR) |-> $past(state_reg) == S_WAIT)
        else $error("write without read");
`endif

endmodule

// File: hdl/mrfe_ctrl.sv
module mrfe_ctrl #(
    parameter int SCREEN_W = mrfe_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H = mrfe_pkg::SCREEN_H_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [mrfe_pkg::MODE_W-1:0]   mode,
    input  logic signed [mrfe_pkg::COORD_W-1:0] x_pos,
    input  logic signed [mrfe_pkg::COORD_W-1:0] y_pos,
    input  logic [mrfe_pkg::SPAN_W-1:0]   span_width,
    input  logic [mrfe_pkg::HEIGHT_W-1:0] rect_height,
    input  logic [mrfe_pkg::RADIUS_W-1:0] radius,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           read_data,
    output logic                 rejected,
    output mrfe_pkg::span_cmd_t  cmd,
    input  mrfe_pkg::span_sts_t  sts,
    input  logic                 clr_busy,
    output logic                 rd_req,
    output logic [$clog2(SCREEN_H)-1:0] rd_row,
    output logic [$clog2((SCREEN_W+7)/8)-1:0] rd_col,
    input  logic [7:0]           rd_data
);
    import mrfe_pkg::*;

    localparam int XW = COORD_W + 2;

    typedef enum logic [3:0] {
        C_IDLE, C_DECODE, C_SPAN, C_SPWAIT, C_RECT, C_CIRC, C_CIRC_STEP,
        C_READ, C_READ2, C_OUT
    } cstate_t;

    cstate_t               state_reg;
    logic [MODE_W-1:0]     mode_reg;
    logic signed [XW-1:0]  x_reg;
    logic signed [XW-1:0]  y_reg;
    logic [SPAN_W-1:0]     w_reg;
    logic [HEIGHT_W-1:0]   h_reg;
    logic [HEIGHT_W-1:0]   row_reg;
    logic signed [XW-1:0]  cx_reg;
    logic signed [XW-1:0]  cy_reg;
    logic signed [XW+1:0]  d_reg;
    logic [1:0]            part_reg;
    logic                  ret_circ_reg;
    logic [7:0]            rd_reg;
    logic                  rej_reg;
    span_cmd_t             cmd_reg;

    logic ok;
    logic rect_done_c;
    logic issue_c;

    assign ok = (x_reg >= 0) && (x_reg < XW'(SCREEN_W))
             && (y_reg >= 0) && (y_reg < XW'(SCREEN_H));
    assign rect_done_c = (row_reg == h_reg) || (y_reg + XW'(row_reg) >= XW'(SCREEN_H));

    // raise the span strobe for one cycle in the states that hand a span down
    always_comb
    begin
        case (state_reg)
            C_DECODE: issue_c = mode_reg inside {MODE_SET_PIXEL, MODE_CLR_PIXEL,
                                                 MODE_SET_BYTE, MODE_CLR_BYTE,
                                                 MODE_SET_SPAN, MODE_CLR_SPAN,
                                                 MODE_XOR_SPAN};
            C_RECT:   issue_c = !rect_done_c;
            C_CIRC:   issue_c = (cy_reg <= cx_reg);
            default:  issue_c = 1'b0;
        endcase
    end

    assign in_ready  = (state_reg == C_IDLE) && !clr_busy;
    assign out_valid = (state_reg == C_OUT);
    assign read_data = rd_reg;
    assign rejected  = rej_reg;
    assign cmd       = cmd_reg;
    assign rd_req    = (state_reg == C_READ);
    assign rd_row    = y_reg[$clog2(SCREEN_H)-1:0];
    assign rd_col    = $bits(rd_col)'(x_reg >>> 3);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= C_IDLE;
            cmd_reg.start <= 1'b0;
        end
        else
        begin
            cmd_reg.start <= issue_c;
            case (state_reg)
                C_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        mode_reg  <= mode;
                        x_reg     <= XW'(x_pos);
                        y_reg     <= XW'(y_pos);
                        w_reg     <= span_width;
                        h_reg     <= rect_height;
                        cx_reg    <= XW'(radius);
                        cy_reg    <= '0;
                        d_reg     <= (XW+2)'(1) - (XW+2)'(radius);
                        part_reg  <= 2'd0;
                        row_reg   <= '0;
                        rd_reg    <= 8'h00;
                        rej_reg   <= 1'b0;
                        state_reg <= C_DECODE;
                    end
                end
                C_DECODE:
                begin
                    ret_circ_reg  <= 1'b0;
                    cmd_reg.y     <= y_reg;
                    cmd_reg.whole <= (mode_reg == MODE_SET_BYTE) || (mode_reg == MODE_CLR_BYTE);
                    case (mode_reg)
                        MODE_SET_PIXEL, MODE_CLR_PIXEL:
                        begin
                            cmd_reg.op    <= (mode_reg == MODE_SET_PIXEL) ? OP_SET : OP_CLR;
                            cmd_reg.x     <= x_reg;
                            cmd_reg.w     <= ok ? XW'(1) : '0;
                            state_reg     <= C_SPWAIT;
                        end
                        MODE_SET_BYTE, MODE_CLR_BYTE:
                        begin
                            cmd_reg.op    <= (mode_reg == MODE_SET_BYTE) ? OP_SET : OP_CLR;
                            cmd_reg.x     <= {x_reg[XW-1:3], 3'b000};
                            cmd_reg.w     <= ok ? XW'(8) : '0;
                            state_reg     <= C_SPWAIT;
                        end
                        MODE_SET_SPAN, MODE_CLR_SPAN, MODE_XOR_SPAN:
                        begin
                            cmd_reg.op    <= (mode_reg == MODE_SET_SPAN) ? OP_SET :
                                             (mode_reg == MODE_CLR_SPAN) ? OP_CLR : OP_XOR;
                            cmd_reg.x     <= x_reg;
                            cmd_reg.w     <= XW'(w_reg);
                            state_reg     <= C_SPWAIT;
                        end
                        MODE_FILL_RECT, MODE_CLR_RECT:
                        begin
                            if (!ok)
                            begin
                                rej_reg   <= 1'b1;
                                state_reg <= C_OUT;
                            end
                            else
                            begin
                                state_reg <= C_RECT;
                            end
                        end
                        MODE_XOR_CIRC:  state_reg <= C_CIRC;
                        MODE_READ_BYTE: state_reg <= ok ? C_READ : C_OUT;
                        default:        state_reg <= C_OUT;
                    endcase
                end
                C_RECT:
                begin
                    if (rect_done_c)
                    begin
                        state_reg <= C_OUT;
                    end
                    else
                    begin
                        cmd_reg.op    <= (mode_reg == MODE_FILL_RECT) ? OP_SET : OP_CLR;
                        cmd_reg.whole <= 1'b0;
                        cmd_reg.x     <= x_reg;
                        cmd_reg.y     <= y_reg + XW'(row_reg);
                        cmd_reg.w     <= XW'(w_reg);
                        row_reg       <= row_reg + HEIGHT_W'(1);
                        state_reg     <= C_SPWAIT;
                    end
                end
                C_CIRC:
                begin
                    // issue one of the four spans of a midpoint step, chosen by part_reg
                    if (cy_reg > cx_reg)
                    begin
                        state_reg <= C_OUT;
                    end
                    else
                    begin
                        cmd_reg.op    <= OP_XOR;
                        cmd_reg.whole <= 1'b0;
                        ret_circ_reg  <= 1'b1;
                        state_reg     <= C_SPWAIT;
                        case (part_reg)
                            2'd0:
                            begin
                                cmd_reg.x <= x_reg - cx_reg;
                                cmd_reg.y <= y_reg + cy_reg;
                                cmd_reg.w <= (cx_reg <<< 1) + XW'(1);
                            end
                            2'd1:
                            begin
                                cmd_reg.x <= x_reg - cx_reg;
                                cmd_reg.y <= y_reg - cy_reg;
                                cmd_reg.w <= (cx_reg <<< 1) + XW'(1);
                            end
                            2'd2:
                            begin
                                cmd_reg.x <= x_reg - cy_reg;
                                cmd_reg.y <= y_reg + cx_reg;
                                cmd_reg.w <= (cy_reg <<< 1) + XW'(1);
                            end
                            default:
                            begin
                                cmd_reg.x <= x_reg - cy_reg;
                                cmd_reg.y <= y_reg - cx_reg;
                                cmd_reg.w <= (cy_reg <<< 1) + XW'(1);
                            end
                        endcase
                    end
                end
                C_SPWAIT:
                begin
                    if (!cmd_reg.start && !sts.busy)
                    begin
                        if (ret_circ_reg)
                        begin
                            part_reg  <= part_reg + 2'd1;
                            state_reg <= (part_reg == 2'd3) ? C_CIRC_STEP : C_CIRC;
                        end
                        else if (mode_reg == MODE_FILL_RECT || mode_reg == MODE_CLR_RECT)
                        begin
                            state_reg <= C_RECT;
                        end
                        else
                        begin
                            state_reg <= C_OUT;
                        end
                    end
                end
                C_CIRC_STEP:
                begin
                    cy_reg <= cy_reg + XW'(1);
                    if (d_reg <= 0)
                    begin
                        d_reg <= d_reg + (XW+2)'((cy_reg <<< 1) + XW'(3));
                    end
                    else
                    begin
                        cx_reg <= cx_reg - XW'(1);
                        d_reg  <= d_reg + (XW+2)'(((cy_reg - cx_reg) <<< 1) + XW'(5));
                    end
                    state_reg <= C_CIRC;
                end
                C_READ:  state_reg <= C_READ2;
                C_READ2:
                begin
                    rd_reg    <= rd_data;
                    state_reg <= C_OUT;
                end
                C_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= C_IDLE;
                    end
                end
                default: state_reg <= C_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    ap_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(read_data))
        else $error("result dropped");
    ap_rej_only_rect: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && rejected) |-> (mode_reg == MODE_FILL_RECT || mode_reg == MODE_CLR_RECT))
        else $error("reject on non rectangle");
    ap_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !sts.busy)
        else $error("accept while drawing");
`endif

endmodule

// File: hdl/mono_raster_fill_engine_unit.sv
// Monochrome raster fill engine: 1 bit per pixel frame buffer, MSB-first,
// (SCREEN_W+7)/8 bytes per row, held in one block RAM.
// Slave channel s_axis_*: one drawing command per request; tuser carries
// mode, tdata carries x_pos, y_pos, span_width, rect_height, radius.
// Master channel m_axis_*: exactly one result per command, tdata carries
// read_data and rejected.
// Each touched byte takes a read-modify-write (S_RD, S_WAIT, S_WR) through the
// RAM's separate read and write ports, plus command decode and result
// hand-off: a span costs one read-modify-write per byte, a rectangle the
// sum of its rows, a circle the sum of its four spans per midpoint step.
// After reset a clearing pass writes zero to every byte, one per cycle
// (SCREEN_H*(SCREEN_W+7)/8 bytes, 32000 at default size); no request is
// taken until it ends.
// The result is held in an output register until m_axis_tready; a stalled
// receiver stalls the engine, and the next request is taken once the result
// has left.
module mono_raster_fill_engine_unit #(
    parameter int SCREEN_W = mrfe_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H = mrfe_pkg::SCREEN_H_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [10:0] x_pos, [21:11] y_pos, [31:22] span_width,
    // [40:32] rect_height, [49:41] radius
    input  logic [55:0] s_axis_tdata,
    // [3:0] mode
    input  logic [7:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] read_data, [8] rejected
    output logic [15:0] m_axis_tdata
);
    import mrfe_pkg::*;

    span_cmd_t  cmd;
    span_sts_t  sts;
    logic       clr_busy;
    logic       rd_req;
    logic [$clog2(SCREEN_H)-1:0]         rd_row;
    logic [$clog2((SCREEN_W+7)/8)-1:0]   rd_col;
    logic [7:0] rd_data;
    logic [7:0] read_data;
    logic       rejected;

    mrfe_ctrl #(.SCREEN_W(SCREEN_W), .SCREEN_H(SCREEN_H)) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .mode        (s_axis_tuser[3:0]),
        .x_pos       (s_axis_tdata[10:0]),
        .y_pos       (s_axis_tdata[21:11]),
        .span_width  (s_axis_tdata[31:22]),
        .rect_height (s_axis_tdata[40:32]),
        .radius      (s_axis_tdata[49:41]),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .read_data   (read_data),
        .rejected    (rejected),
        .cmd         (cmd),
        .sts         (sts),
        .clr_busy    (clr_busy),
        .rd_req      (rd_req),
        .rd_row      (rd_row),
        .rd_col      (rd_col),
        .rd_data     (rd_data)
    );

    mrfe_datapath #(.SCREEN_W(SCREEN_W), .SCREEN_H(SCREEN_H)) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .rd_req   (rd_req),
        .rd_row   (rd_row),
        .rd_col   (rd_col),
        .rd_data  (rd_data),
        .clr_busy (clr_busy)
    );

    assign m_axis_tdata = {7'd0, rejected, read_data};

endmodule
